>>> rtl/hltb_pkg.sv
// ----------------------------------------------------------------------------
// hltb_pkg
// shared types and constants of the height layer texel blend
// ----------------------------------------------------------------------------
package hltb_pkg;

  // fixed widths
  localparam int HEIGHT_W = 8;
  localparam int TEXEL_W  = 24;
  localparam int CHAN_W   = 8;
  localparam int BOUNDS_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W  = 3;
  localparam int SLOTS    = 4;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd4;

  // one lane request after classification
  typedef struct packed {
    logic [HEIGHT_W-1:0] num;
    logic [HEIGHT_W-1:0] den;
    logic                one;
    logic                zero;
    logic [TEXEL_W-1:0]  texel;
  } hltb_lane_t;

endpackage

>>> rtl/height_layer_texel_blend.sv
// ----------------------------------------------------------------------------
// height_layer_texel_blend
// height-driven splatting of up to four texture layers into one rgb pixel
// ----------------------------------------------------------------------------
// One pixel request enters per clock and one result leaves per clock when the
// downstream side keeps up. A request passes the band classification stage, one
// stage per weight bit in the pipelined ramp divider of each layer, then product,
// sum and saturation stages. Each stage holds its own valid bit and only stalls
// when full and the next stage stalls, so bubbles collapse under backpressure.
// Layer thresholds and the layer count are written on the cfg port; the user must
// do so only while no request is in flight, the block does not enforce it.
// ----------------------------------------------------------------------------
module height_layer_texel_blend
  import hltb_pkg::*;
#(
  parameter int LAYERS           = 4,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BOUNDS_W-1:0]  cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // height, texel_a, texel_b, texel_c, texel_d
  input  logic [103:0]         s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // red, green, blue, clipped, zero fill
  output logic [31:0]          m_tdata
);

  localparam int LANES = (LAYERS < SLOTS) ? LAYERS : SLOTS;
  localparam int FRAC  = WEIGHT_FRAC_BITS;
  localparam int DEPTH = FRAC + 4;

  logic [BOUNDS_W-1:0] bounds [LANES];
  logic [COUNT_W-1:0]  layer_count;
  logic [DEPTH-1:0]    vld;
  logic [DEPTH-1:0]    en;
  hltb_lane_t          lane   [LANES];
  logic [FRAC:0]       weight [LANES];
  logic [TEXEL_W-1:0]  texel  [LANES];
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic                clipped;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= COUNT_RESET;
    end else if (cfg_we && cfg_index == CFG_LAYER_COUNT) begin
      layer_count <= cfg_data[COUNT_W-1:0];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_bounds
    always_ff @(posedge clk) begin
      if (rst) begin
        bounds[l] <= '0;
      end else if (cfg_we && cfg_index == CFG_LAYER0 + CFG_IDX_W'(l)) begin
        bounds[l] <= cfg_data;
      end
    end
  end

  // stage advance: a stage moves when it is empty or the next one moves
  for (genvar k = 0; k < DEPTH; k++) begin : g_en
    if (k == DEPTH - 1) begin : g_last
      assign en[k] = !vld[k] || m_tready;
    end else begin : g_mid
      assign en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = en[0] && !rst;
  assign m_tvalid = vld[DEPTH-1];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    hltb_classify u_classify (
      .clk    (clk),
      .en     (en[0]),
      .active (layer_count > COUNT_W'(l)),
      .height (s_tdata[HEIGHT_W-1:0]),
      .bounds (bounds[l]),
      .texel  (s_tdata[HEIGHT_W + TEXEL_W*l +: TEXEL_W]),
      .lane   (lane[l])
    );

    hltb_ramp_div #(
      .FRAC (FRAC)
    ) u_div (
      .clk    (clk),
      .en     (en[FRAC:1]),
      .lane   (lane[l]),
      .weight (weight[l]),
      .texel  (texel[l])
    );
  end

  hltb_blend #(
    .FRAC  (FRAC),
    .LANES (LANES)
  ) u_blend (
    .clk     (clk),
    .en      (en[FRAC+3:FRAC+1]),
    .weight  (weight),
    .texel   (texel),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .clipped (clipped)
  );

  assign m_tdata = {7'd0, clipped, blue, green, red};

endmodule

>>> rtl/hltb_classify.sv
// ----------------------------------------------------------------------------
// hltb_classify
// trapezoid band test for one layer, registered ramp numerator and denominator
// ----------------------------------------------------------------------------
module hltb_classify
  import hltb_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  logic                active,
  input  logic [HEIGHT_W-1:0] height,
  input  logic [BOUNDS_W-1:0] bounds,
  input  logic [TEXEL_W-1:0]  texel,
  output hltb_lane_t          lane
);

  logic [HEIGHT_W-1:0] fmin;
  logic [HEIGHT_W-1:0] fmax;
  logic [HEIGHT_W-1:0] nmin;
  logic [HEIGHT_W-1:0] nmax;
  logic                full;
  logic                outside;
  hltb_lane_t          lane_next;

  assign fmin = bounds[7:0];
  assign fmax = bounds[15:8];
  assign nmin = bounds[23:16];
  assign nmax = bounds[31:24];

  assign full    = (height <= fmax) && (height >= fmin);
  assign outside = (height >= nmax) || (height <= nmin);

  always_comb begin
    lane_next.texel = texel;
    lane_next.one   = active && full;
    lane_next.zero  = !active || (!full && outside);
    if (height < fmin) begin
      // rising ramp below the full band
      lane_next.num = height - nmin;
      lane_next.den = fmin - nmin;
    end else begin
      // falling ramp above the full band
      lane_next.num = nmax - height;
      lane_next.den = nmax - fmax;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane <= lane_next;
    end
  end

endmodule

>>> rtl/hltb_ramp_div.sv
// ----------------------------------------------------------------------------
// hltb_ramp_div
// pipelined restoring divider, one weight bit per stage, for one layer
// ----------------------------------------------------------------------------
module hltb_ramp_div
  import hltb_pkg::*;
#(
  parameter int FRAC = 16
) (
  input  logic               clk,
  input  logic [FRAC-1:0]    en,
  input  hltb_lane_t         lane,
  output logic [FRAC:0]      weight,
  output logic [TEXEL_W-1:0] texel
);

  logic [HEIGHT_W-1:0] rem   [FRAC];
  logic [FRAC-1:0]     quo   [FRAC];
  logic [HEIGHT_W-1:0] den   [FRAC];
  logic                one   [FRAC];
  logic                zero  [FRAC];
  logic [TEXEL_W-1:0]  tex   [FRAC];

  for (genvar s = 0; s < FRAC; s++) begin : g_step
    logic [HEIGHT_W-1:0] rem_in;
    logic [FRAC-1:0]     quo_in;
    logic [HEIGHT_W-1:0] den_in;
    logic                one_in;
    logic                zero_in;
    logic [TEXEL_W-1:0]  tex_in;
    logic [HEIGHT_W:0]   shifted;
    logic                ge;
    logic [HEIGHT_W:0]   diff;

    if (s == 0) begin : g_first
      assign rem_in  = lane.num;
      assign quo_in  = '0;
      assign den_in  = lane.den;
      assign one_in  = lane.one;
      assign zero_in = lane.zero;
      assign tex_in  = lane.texel;
    end else begin : g_next
      assign rem_in  = rem[s-1];
      assign quo_in  = quo[s-1];
      assign den_in  = den[s-1];
      assign one_in  = one[s-1];
      assign zero_in = zero[s-1];
      assign tex_in  = tex[s-1];
    end

    assign shifted = {rem_in, 1'b0};
    assign ge      = shifted >= {1'b0, den_in};
    assign diff    = shifted - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en[s]) begin
        // remainder stays below the divisor, so it fits in eight bits
        rem[s]  <= ge ? diff[HEIGHT_W-1:0] : shifted[HEIGHT_W-1:0];
        quo[s]  <= {quo_in[FRAC-2:0], ge};
        den[s]  <= den_in;
        one[s]  <= one_in;
        zero[s] <= zero_in;
        tex[s]  <= tex_in;
      end
    end
  end

  always_comb begin
    if (one[FRAC-1]) begin
      weight = {1'b1, {FRAC{1'b0}}};
    end else if (zero[FRAC-1]) begin
      weight = '0;
    end else begin
      weight = {1'b0, quo[FRAC-1]};
    end
  end

  assign texel = tex[FRAC-1];

endmodule

>>> rtl/hltb_blend.sv
// ----------------------------------------------------------------------------
// hltb_blend
// weighted channel products, per-channel sums and saturation to eight bits
// ----------------------------------------------------------------------------
module hltb_blend
  import hltb_pkg::*;
#(
  parameter int FRAC  = 16,
  parameter int LANES = 4
) (
  input  logic               clk,
  input  logic [2:0]         en,
  input  logic [FRAC:0]      weight [LANES],
  input  logic [TEXEL_W-1:0] texel  [LANES],
  output logic [CHAN_W-1:0]  red,
  output logic [CHAN_W-1:0]  green,
  output logic [CHAN_W-1:0]  blue,
  output logic               clipped
);

  localparam int PROD_W = CHAN_W + FRAC + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int INT_W  = SUM_W - FRAC;

  logic [PROD_W-1:0] prod [LANES][3];
  logic [SUM_W-1:0]  sum  [3];
  logic [SUM_W-1:0]  sum_next [3];
  logic [INT_W-1:0]  whole [3];
  logic [2:0]        over;
  logic [CHAN_W-1:0] chan [3];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar c = 0; c < 3; c++) begin : g_chan
      always_ff @(posedge clk) begin
        if (en[0]) begin
          prod[l][c] <= PROD_W'(texel[l][CHAN_W*c +: CHAN_W]) * PROD_W'(weight[l]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_next[c] = '0;
      for (int l = 0; l < LANES; l++) begin
        sum_next[c] = sum_next[c] + SUM_W'(prod[l][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum <= sum_next;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_sat
    assign whole[c] = sum[c][SUM_W-1:FRAC];
    assign over[c]  = |whole[c][INT_W-1:CHAN_W];
    assign chan[c]  = over[c] ? {CHAN_W{1'b1}} : whole[c][CHAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      red     <= chan[0];
      green   <= chan[1];
      blue    <= chan[2];
      clipped <= |over;
    end
  end

endmodule
